// ===== hw/rtl/gaussian_splat_attribute_decode_unit_defines.svh =====
// Assertion macros shared by the splat attribute decoder.
// Each macro expects signals named aclk and aresetn in the scope of use.
`ifndef GAUSSIAN_SPLAT_ATTRIBUTE_DECODE_UNIT_DEFINES_SVH
`define GAUSSIAN_SPLAT_ATTRIBUTE_DECODE_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define GSAD_ASSERT_NOW(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define GSAD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gsad_pkg.sv =====
package gsad_pkg;

    typedef struct packed {
        logic signed [15:0] sh_dc_red;
        logic signed [15:0] sh_dc_green;
        logic signed [15:0] sh_dc_blue;
        logic signed [15:0] log_scale_x;
        logic signed [15:0] log_scale_y;
        logic signed [15:0] log_scale_z;
        logic signed [15:0] quat_w_raw;
        logic signed [15:0] quat_x_raw;
        logic signed [15:0] quat_y_raw;
        logic signed [15:0] quat_z_raw;
    } in_item_t;

    typedef struct packed {
        logic [12:0]        color_red;
        logic [12:0]        color_green;
        logic [12:0]        color_blue;
        logic [31:0]        scale_x;
        logic [31:0]        scale_y;
        logic [31:0]        scale_z;
        logic signed [15:0] quat_w_unit;
        logic signed [15:0] quat_x_unit;
        logic signed [15:0] quat_y_unit;
        logic signed [15:0] quat_z_unit;
    } out_item_t;

    // Side information that follows a quaternion through the square root.
    typedef struct packed {
        logic [3:0][15:0] mag;
        logic [3:0]       neg;
        logic             zero;
    } nrm_side_t;

    // Side information that follows a quaternion through the divider.
    typedef struct packed {
        logic [3:0] neg;
        logic       zero;
    } nrm_div_side_t;

    // Colour: C0 in Q0.16, and the offset of one half plus rounding.
    localparam logic signed [33:0] COLOR_C0   = 34'sd18487;
    localparam logic signed [33:0] COLOR_BIAS = 34'sd134250496;
    localparam logic [12:0]        COLOR_ONE  = 13'd4096;

    // Exponential.
    localparam int          EXP_TERMS      = 13;
    localparam int          EXP_MAX_N      = 23;
    localparam logic [36:0] LN2_Q32        = 37'h0B17217F8;
    localparam logic [36:0] EXP_OFFSET     = 37'(12) * LN2_Q32;
    localparam logic [32:0] TERM_ONE       = 33'h1_0000_0000;
    localparam logic [4:0]  EXP_SHIFT_BASE = 5'd28;

    // floor(2^33 / k) for the division of each series term by k.
    localparam logic [33:0] RECIP [2:13] = '{
        34'd4294967296, 34'd2863311530, 34'd2147483648, 34'd1717986918,
        34'd1431655765, 34'd1227133513, 34'd1073741824, 34'd954437176,
        34'd858993459,  34'd780903144,  34'd715827882,  34'd660764199
    };

    // Quaternion normalisation.
    localparam int          SQRT_STAGES   = 32;
    localparam int          SQRT_DATA_STG = 16;
    localparam int          DIV_STAGES    = 15;
    localparam logic [14:0] UNIT_ONE      = 15'd16384;

    // Pipeline depths.
    localparam int EXP_LAT   = 43;
    localparam int NRM_LAT   = 50;
    localparam int PIPE_LAT  = NRM_LAT;
    localparam int SCALE_DLY = PIPE_LAT - EXP_LAT;

    function automatic logic [36:0] ln2_multiple(input logic [4:0] m);
        return 37'(m) * LN2_Q32;
    endfunction

endpackage

// ===== hw/rtl/gsad_exp.sv =====
module gsad_exp (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] log_scale,
    output logic [31:0]        scale
);
    import gsad_pkg::*;

    logic [36:0] off_reg;
    logic [36:0] off2_reg;
    logic [4:0]  q_reg;
    logic [4:0]  q_next;
    logic [31:0] r_reg;
    logic [4:0]  n_reg;

    logic [31:0] pa_reg   [1:EXP_TERMS];
    logic [32:0] suma_reg [1:EXP_TERMS];
    logic [4:0]  na_reg   [1:EXP_TERMS];
    logic [31:0] pb_reg   [1:EXP_TERMS];
    logic [31:0] qb_reg   [1:EXP_TERMS];
    logic [32:0] sumb_reg [1:EXP_TERMS];
    logic [4:0]  nb_reg   [1:EXP_TERMS];
    logic [32:0] termc_reg[1:EXP_TERMS];
    logic [32:0] sumc_reg [1:EXP_TERMS];
    logic [4:0]  nc_reg   [1:EXP_TERMS];
    logic [31:0] ra_reg   [1:EXP_TERMS-1];
    logic [31:0] rb_reg   [1:EXP_TERMS-1];
    logic [31:0] rc_reg   [1:EXP_TERMS-1];

    logic [4:0]  shift;
    logic [33:0] total;
    logic [31:0] scale_reg;

    // The offset of twelve ln2 keeps the reduced argument positive.
    always_ff @(posedge aclk) begin
        if (en) begin
            off_reg <= {log_scale[15], log_scale, 20'b0} + EXP_OFFSET;
        end
    end

    always_comb begin
        q_next = '0;
        for (int j = 1; j <= EXP_MAX_N; j++) begin
            if (off_reg >= ln2_multiple(5'(j))) begin
                q_next = 5'(j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg    <= q_next;
            off2_reg <= off_reg;
            r_reg    <= 32'(off2_reg - ln2_multiple(q_reg));
            n_reg    <= q_reg;
        end
    end

    // Each series term takes three stages: multiply by r, multiply by the
    // reciprocal of k, then correct the quotient by at most one.
    for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
        logic [32:0] term_in;
        logic [32:0] sum_in;
        logic [31:0] r_in;
        logic [4:0]  n_in;
        logic [64:0] prod;
        logic [31:0] rem;
        logic        fix;

        if (k == 1) begin : g_first
            assign term_in = TERM_ONE;
            assign sum_in  = '0;
            assign r_in    = r_reg;
            assign n_in    = n_reg;
        end else begin : g_chain
            assign term_in = termc_reg[k-1];
            assign sum_in  = sumc_reg[k-1];
            assign r_in    = rc_reg[k-1];
            assign n_in    = nc_reg[k-1];
        end

        assign prod = 65'(term_in) * 65'(r_in);

        always_ff @(posedge aclk) begin
            if (en) begin
                pa_reg[k]   <= prod[63:32];
                suma_reg[k] <= sum_in + term_in;
                na_reg[k]   <= n_in;
                pb_reg[k]   <= pa_reg[k];
                sumb_reg[k] <= suma_reg[k];
                nb_reg[k]   <= na_reg[k];
            end
        end

        if (k == 1) begin : g_div_one
            always_ff @(posedge aclk) begin
                if (en) begin
                    qb_reg[k] <= pa_reg[k];
                end
            end
        end else begin : g_div_k
            logic [65:0] qprod;
            assign qprod = 66'(pa_reg[k]) * 66'(RECIP[k]);
            always_ff @(posedge aclk) begin
                if (en) begin
                    qb_reg[k] <= qprod[64:33];
                end
            end
        end

        assign rem = pb_reg[k] - qb_reg[k] * 32'(k);
        assign fix = (rem >= 32'(k));

        always_ff @(posedge aclk) begin
            if (en) begin
                termc_reg[k] <= 33'(qb_reg[k]) + 33'(fix);
                sumc_reg[k]  <= sumb_reg[k];
                nc_reg[k]    <= nb_reg[k];
            end
        end

        if (k < EXP_TERMS) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    ra_reg[k] <= r_in;
                    rb_reg[k] <= ra_reg[k];
                    rc_reg[k] <= rb_reg[k];
                end
            end
        end
    end

    // The last term joins the sum here, together with the rounding half.
    assign shift = EXP_SHIFT_BASE - nc_reg[EXP_TERMS];
    assign total = 34'(sumc_reg[EXP_TERMS]) + 34'(termc_reg[EXP_TERMS])
                 + (34'd1 << (shift - 5'd1));

    always_ff @(posedge aclk) begin
        if (en) begin
            scale_reg <= 32'(total >> shift);
        end
    end

    assign scale = scale_reg;

endmodule

// ===== hw/rtl/gsad_norm.sv =====
module gsad_norm (
    input  logic             aclk,
    input  logic             en,
    input  logic [3:0][15:0] quat_raw,
    output logic [3:0][15:0] quat_unit
);
    import gsad_pkg::*;

    logic [3:0][30:0] sq_reg;
    nrm_side_t        side1_reg;
    nrm_side_t        side1_next;
    logic [32:0]      ssum_reg;
    nrm_side_t        side2_reg;

    logic [31:0]      root_reg [0:SQRT_STAGES-1];
    logic [33:0]      rem_reg  [0:SQRT_STAGES-1];
    nrm_side_t        sside_reg[0:SQRT_STAGES-1];
    logic [32:0]      s_reg    [0:SQRT_DATA_STG-1];

    logic [3:0][45:0] drem_reg [0:DIV_STAGES-2];
    logic [31:0]      len_reg  [0:DIV_STAGES-2];
    logic [3:0][14:0] quo_reg  [0:DIV_STAGES-1];
    nrm_div_side_t    dside_reg[0:DIV_STAGES-1];

    logic [3:0][15:0] unit_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            side1_next.mag[i] = quat_raw[i][15] ? 16'(-quat_raw[i]) : quat_raw[i];
            side1_next.neg[i] = quat_raw[i][15];
        end
        side1_next.zero = (quat_raw == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                sq_reg[i] <= 31'($signed(quat_raw[i]) * $signed(quat_raw[i]));
            end
            side1_reg <= side1_next;
            ssum_reg  <= 33'(sq_reg[0]) + 33'(sq_reg[1]) + 33'(sq_reg[2]) + 33'(sq_reg[3]);
            side2_reg <= side1_reg;
        end
    end

    // Digit-by-digit square root of S * 2^30, one root bit per stage.
    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
        logic [31:0] root_in;
        logic [33:0] rem_in;
        nrm_side_t   side_in;
        logic [1:0]  bits;
        logic [35:0] cur;
        logic [35:0] trial;
        logic        ge;

        if (j == 0) begin : g_first
            assign root_in = '0;
            assign rem_in  = '0;
            assign side_in = side2_reg;
        end else begin : g_chain
            assign root_in = root_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign side_in = sside_reg[j-1];
        end

        if (j <= SQRT_DATA_STG) begin : g_bits
            logic [32:0] s_in;
            logic [63:0] numw;
            if (j == 0) begin : g_src0
                assign s_in = ssum_reg;
            end else begin : g_srcn
                assign s_in = s_reg[j-1];
            end
            assign numw = {1'b0, s_in, 30'b0};
            assign bits = numw[63-2*j -: 2];
            if (j < SQRT_DATA_STG) begin : g_keep
                always_ff @(posedge aclk) begin
                    if (en) begin
                        s_reg[j] <= s_in;
                    end
                end
            end
        end else begin : g_zero_bits
            assign bits = 2'b00;
        end

        assign cur   = {rem_in, bits};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]   <= ge ? 34'(cur - trial) : cur[33:0];
                root_reg[j]  <= {root_in[30:0], ge};
                sside_reg[j] <= side_in;
            end
        end
    end

    // Restoring division of |q| * 2^29 + L/2 by L, one quotient bit per stage.
    for (genvar t = 0; t < DIV_STAGES; t++) begin : g_div
        logic [3:0][45:0] drem_in;
        logic [31:0]      len_in;
        logic [3:0][14:0] quo_in;
        nrm_div_side_t    dside_in;
        logic [45:0]      dvsr;
        logic [3:0]       ge;

        if (t == 0) begin : g_first
            assign len_in        = root_reg[SQRT_STAGES-1];
            assign quo_in        = '0;
            assign dside_in.neg  = sside_reg[SQRT_STAGES-1].neg;
            assign dside_in.zero = sside_reg[SQRT_STAGES-1].zero;
            for (genvar i = 0; i < 4; i++) begin : g_lane
                assign drem_in[i] = 46'({sside_reg[SQRT_STAGES-1].mag[i], 29'b0})
                                  + 46'(root_reg[SQRT_STAGES-1][31:1]);
            end
        end else begin : g_chain
            assign len_in   = len_reg[t-1];
            assign quo_in   = quo_reg[t-1];
            assign dside_in = dside_reg[t-1];
            assign drem_in  = drem_reg[t-1];
        end

        assign dvsr = 46'(len_in) << (DIV_STAGES - 1 - t);

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                ge[i] = (drem_in[i] >= dvsr);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 4; i++) begin
                    quo_reg[t][i] <= {quo_in[i][13:0], ge[i]};
                end
                dside_reg[t] <= dside_in;
            end
        end

        if (t < DIV_STAGES - 1) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    for (int i = 0; i < 4; i++) begin
                        drem_reg[t][i] <= ge[i] ? drem_in[i] - dvsr : drem_in[i];
                    end
                    len_reg[t] <= len_in;
                end
            end
        end
    end

    // A zero-length quaternion has a zero root; its quotient is discarded.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                if (dside_reg[DIV_STAGES-1].zero) begin
                    unit_reg[i] <= '0;
                end else if (quo_reg[DIV_STAGES-1][i] > UNIT_ONE) begin
                    unit_reg[i] <= dside_reg[DIV_STAGES-1].neg[i] ?
                                   16'(-{1'b0, UNIT_ONE}) : {1'b0, UNIT_ONE};
                end else begin
                    unit_reg[i] <= dside_reg[DIV_STAGES-1].neg[i] ?
                                   16'(-{1'b0, quo_reg[DIV_STAGES-1][i]}) :
                                   {1'b0, quo_reg[DIV_STAGES-1][i]};
                end
            end
        end
    end

    assign quat_unit = unit_reg;

endmodule

// ===== hw/rtl/gaussian_splat_attribute_decode_unit.sv =====
// Throughput: one item per cycle; the quaternion square root (32 stages)
// and divider (15 stages) set the depth, the exponential unit takes 43.
// The whole pipeline advances together and holds while a result is stalled.
// Reset (aresetn, synchronous, active low) clears only the valid bits.
`include "gaussian_splat_attribute_decode_unit_defines.svh"

module gaussian_splat_attribute_decode_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gsad_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output gsad_pkg::out_item_t  m_data
);
    import gsad_pkg::*;

    logic                 pipe_en;
    logic [PIPE_LAT-1:0]  vld_reg;
    logic [2:0][12:0]     col_reg [0:PIPE_LAT-1];
    logic [2:0][12:0]     col_next;
    logic [2:0][15:0]     log_in;
    logic [2:0][31:0]     exp_out;
    logic [2:0][31:0]     scl_reg [0:SCALE_DLY-1];
    logic [3:0][15:0]     quat_in;
    logic [3:0][15:0]     quat_out;
    logic                 colour_ok;
    logic                 quat_ok;
    logic                 scale_ok;

    function automatic logic [12:0] color_of(input logic signed [15:0] dc);
        logic signed [33:0] t;
        t = 34'(dc) * COLOR_C0 + COLOR_BIAS;
        if (t[33]) begin
            return '0;
        end else if (t[32:16] > 17'(COLOR_ONE)) begin
            return COLOR_ONE;
        end else begin
            return t[28:16];
        end
    endfunction

    function automatic logic unit_in_range(input logic signed [15:0] v);
        return (v >= -16'sd16384) && (v <= 16'sd16384);
    endfunction

    assign pipe_en = m_ready || !vld_reg[PIPE_LAT-1];
    assign s_ready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    assign col_next[0] = color_of(s_data.sh_dc_red);
    assign col_next[1] = color_of(s_data.sh_dc_green);
    assign col_next[2] = color_of(s_data.sh_dc_blue);

    // The colours are ready after one stage and wait for the other lanes.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            col_reg[0] <= col_next;
            for (int i = 1; i < PIPE_LAT; i++) begin
                col_reg[i] <= col_reg[i-1];
            end
        end
    end

    assign log_in = {s_data.log_scale_z, s_data.log_scale_y, s_data.log_scale_x};

    for (genvar i = 0; i < 3; i++) begin : g_exp
        gsad_exp u_exp (
            .aclk      (aclk),
            .en        (pipe_en),
            .log_scale (log_in[i]),
            .scale     (exp_out[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            scl_reg[0] <= exp_out;
            for (int i = 1; i < SCALE_DLY; i++) begin
                scl_reg[i] <= scl_reg[i-1];
            end
        end
    end

    assign quat_in = {s_data.quat_z_raw, s_data.quat_y_raw,
                      s_data.quat_x_raw, s_data.quat_w_raw};

    gsad_norm u_norm (
        .aclk      (aclk),
        .en        (pipe_en),
        .quat_raw  (quat_in),
        .quat_unit (quat_out)
    );

    assign m_valid             = vld_reg[PIPE_LAT-1];
    assign m_data.color_red    = col_reg[PIPE_LAT-1][0];
    assign m_data.color_green  = col_reg[PIPE_LAT-1][1];
    assign m_data.color_blue   = col_reg[PIPE_LAT-1][2];
    assign m_data.scale_x      = scl_reg[SCALE_DLY-1][0];
    assign m_data.scale_y      = scl_reg[SCALE_DLY-1][1];
    assign m_data.scale_z      = scl_reg[SCALE_DLY-1][2];
    assign m_data.quat_w_unit  = quat_out[0];
    assign m_data.quat_x_unit  = quat_out[1];
    assign m_data.quat_y_unit  = quat_out[2];
    assign m_data.quat_z_unit  = quat_out[3];

    assign colour_ok = (m_data.color_red <= COLOR_ONE) && (m_data.color_green <= COLOR_ONE)
                     && (m_data.color_blue <= COLOR_ONE);
    assign quat_ok   = unit_in_range(m_data.quat_w_unit) && unit_in_range(m_data.quat_x_unit)
                     && unit_in_range(m_data.quat_y_unit) && unit_in_range(m_data.quat_z_unit);
    assign scale_ok  = (m_data.scale_x[31:28] == 4'd0) && (m_data.scale_y[31:28] == 4'd0)
                     && (m_data.scale_z[31:28] == 4'd0);

    `GSAD_ASSERT_NOW(a_colour_range, !m_valid || colour_ok, "Colour above one.")

    `GSAD_ASSERT_NOW(a_quat_range, !m_valid || quat_ok, "Quaternion part out of range.")

    `GSAD_ASSERT_NOW(a_scale_bound, !m_valid || scale_ok, "Scale beyond the reachable range.")

    `GSAD_ASSERT_NEXT(a_pipe_frozen, !s_ready, $stable(vld_reg) && $stable(m_data), "Pipeline moved while stalled.")

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import gsad_pkg::*;

    localparam int LATENCY    = 50;
    localparam int STALL_WAIT = 4000;
    localparam longint unsigned LN2_FIX = 64'hB17217F8;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    out_item_t pending_attrs[$];
    int        mismatches = 0;
    int        sender_idle_pct = 0;
    int        receiver_idle_pct = 0;
    int        hold_off_cycles = 0;
    int        quiet_cycles = 0;

    gaussian_splat_attribute_decode_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic logic [12:0] colour_of(input logic signed [15:0] dc);
        longint t;
        t = longint'(dc) * 18487 + 64'sd134217728 + 32768;
        if (t < 0) return 13'd0;
        t = t >>> 16;
        return (t > 4096) ? 13'd4096 : 13'(t);
    endfunction

    function automatic logic [31:0] extent_of(input logic signed [15:0] lg);
        longint          x;
        longint unsigned off, q, r, term, sum, res;
        int              n, s;
        x = longint'(lg) * 64'sd1048576;
        off = longint'(x) + 12 * LN2_FIX;
        q = off / LN2_FIX;
        r = off - q * LN2_FIX;
        term = 64'd1 << 32;
        sum = term;
        for (int k = 1; k <= 13; k++) begin
            term = ((term * r) >> 32) / k;
            sum += term;
        end
        n = int'(q) - 12;
        s = 16 - n;
        if (s <= 0) return 32'hFFFF_FFFF;
        if (s >= 63) return 32'd0;
        res = (sum + (64'd1 << (s - 1))) >> s;
        return (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned num);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > num) b >>= 2;
        while (b != 0) begin
            if (num >= res + b) begin
                num -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] unit_of(input logic signed [15:0] q,
                                            input longint unsigned len);
        longint unsigned mag, m;
        mag = (q < 0) ? longint'(-longint'(q)) : longint'(q);
        m = ((mag << 29) + (len >> 1)) / len;
        if (m > 16384) m = 16384;
        return (q < 0) ? 16'(-m) : 16'(m);
    endfunction

    function automatic out_item_t decode_record(input in_item_t rec);
        out_item_t       o;
        longint unsigned sq, len;
        o.color_red   = colour_of(rec.sh_dc_red);
        o.color_green = colour_of(rec.sh_dc_green);
        o.color_blue  = colour_of(rec.sh_dc_blue);
        o.scale_x     = extent_of(rec.log_scale_x);
        o.scale_y     = extent_of(rec.log_scale_y);
        o.scale_z     = extent_of(rec.log_scale_z);
        sq = longint'(rec.quat_w_raw) * rec.quat_w_raw + longint'(rec.quat_x_raw) * rec.quat_x_raw
           + longint'(rec.quat_y_raw) * rec.quat_y_raw + longint'(rec.quat_z_raw) * rec.quat_z_raw;
        if (sq == 0) begin
            o.quat_w_unit = '0;
            o.quat_x_unit = '0;
            o.quat_y_unit = '0;
            o.quat_z_unit = '0;
        end else begin
            len = int_sqrt(sq << 30);
            o.quat_w_unit = unit_of(rec.quat_w_raw, len);
            o.quat_x_unit = unit_of(rec.quat_x_raw, len);
            o.quat_y_unit = unit_of(rec.quat_y_raw, len);
            o.quat_z_unit = unit_of(rec.quat_z_raw, len);
        end
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout bit bad);
        if (want !== got) begin
            bad = 1'b1;
            if (mismatches < 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    task automatic check_attrs(input out_item_t want, input out_item_t got);
        bit bad;
        bad = 1'b0;
        check_field("color_red", 32'(want.color_red), 32'(got.color_red), bad);
        check_field("color_green", 32'(want.color_green), 32'(got.color_green), bad);
        check_field("color_blue", 32'(want.color_blue), 32'(got.color_blue), bad);
        check_field("scale_x", want.scale_x, got.scale_x, bad);
        check_field("scale_y", want.scale_y, got.scale_y, bad);
        check_field("scale_z", want.scale_z, got.scale_z, bad);
        check_field("quat_w_unit", 32'(want.quat_w_unit), 32'(got.quat_w_unit), bad);
        check_field("quat_x_unit", 32'(want.quat_x_unit), 32'(got.quat_x_unit), bad);
        check_field("quat_y_unit", 32'(want.quat_y_unit), 32'(got.quat_y_unit), bad);
        check_field("quat_z_unit", 32'(want.quat_z_unit), 32'(got.quat_z_unit), bad);
        if (bad) mismatches++;
    endtask

    // Receiver: a requested hold-off takes precedence over random stalls.
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Predicts on input acceptance, checks on output acceptance, and watches
    // for a channel that has stopped moving.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_attrs.push_back(decode_record(s_data));
            if (m_valid && m_ready) begin
                if (pending_attrs.size() == 0) begin
                    if (mismatches < 10) $display("unexpected result item %p", m_data);
                    mismatches++;
                end else begin
                    check_attrs(pending_attrs.pop_front(), m_data);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_WAIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_record(input in_item_t rec);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rec;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(65535));
            1:       return 16'($signed($urandom_range(8000)) - 4000);
            2:       return 16'($signed($urandom_range(60000)) - 30000);
            default: return ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
        endcase
    endfunction

    function automatic in_item_t random_record();
        in_item_t rec;
        rec = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        rec.sh_dc_red   = pick_value();
        rec.sh_dc_green = pick_value();
        rec.sh_dc_blue  = pick_value();
        rec.log_scale_x = pick_value();
        rec.log_scale_y = pick_value();
        rec.log_scale_z = pick_value();
        // A quarter of quaternions are small or zero so the normaliser sees them.
        if ($urandom_range(3) == 0) begin
            rec.quat_w_raw = 16'($signed($urandom_range(4)) - 2);
            rec.quat_x_raw = 16'($signed($urandom_range(4)) - 2);
            rec.quat_y_raw = 16'($signed($urandom_range(4)) - 2);
            rec.quat_z_raw = 16'($signed($urandom_range(4)) - 2);
        end
        return rec;
    endfunction

    function automatic in_item_t make_record(input logic [15:0] dc, input logic [15:0] lg,
                                             input logic [15:0] w, input logic [15:0] x,
                                             input logic [15:0] y, input logic [15:0] z);
        return '{dc, dc, dc, lg, lg, lg, w, x, y, z};
    endfunction

    task automatic test_colour_limits();
        send_record(make_record(16'h8000, 16'h0000, 16'd4096, 16'd0, 16'd0, 16'd0));
        send_record(make_record(16'h7FFF, 16'h0000, 16'd4096, 16'd0, 16'd0, 16'd0));
        send_record(make_record(16'd7260, 16'h0000, 16'd4096, 16'd0, 16'd0, 16'd0));
        send_record(make_record(-16'sd7261, 16'h0000, 16'd4096, 16'd0, 16'd0, 16'd0));
        send_record('{16'd0, 16'd1, -16'sd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0});
    endtask

    task automatic test_scale_limits();
        send_record(make_record(16'd0, 16'h8000, 16'd1, 16'd1, 16'd1, 16'd1));
        send_record(make_record(16'd0, 16'h7FFF, 16'd1, 16'd1, 16'd1, 16'd1));
        send_record(make_record(16'd0, -16'sd32000, 16'd1, 16'd1, 16'd1, 16'd1));
        send_record('{16'd0, 16'd0, 16'd0, -16'sd1, 16'd1, 16'd2839, 16'd0, 16'd0, 16'd0, 16'd1});
        send_record(make_record(16'd0, -16'sd28000, 16'd1, 16'd1, 16'd1, 16'd1));
    endtask

    task automatic test_rotation_cases();
        // A zero-length quaternion must give all zero parts.
        send_record(make_record(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_record(make_record(16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0));
        send_record(make_record(16'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_record(make_record(16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        send_record(make_record(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, -16'sd1));
        send_record(make_record(16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1));
        send_record(make_record(16'd0, 16'd0, 16'd3, -16'sd4, 16'd0, 16'd0));
        send_record(make_record(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_record(make_record(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        repeat (count) send_record(random_record());
    endtask

    task automatic test_full_pipeline();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        @(posedge aclk);
        hold_off_cycles <= 200;
        repeat (120) send_record(random_record());
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sender_idle_pct   = 26;
        receiver_idle_pct = 58;
        test_colour_limits();
        test_scale_limits();
        test_rotation_cases();
        test_random(380, 26, 58);
        test_full_pipeline();
        test_random(380, 58, 26);
        test_random(220, 0, 0);
        s_valid <= 1'b0;
        while (pending_attrs.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
